// ===== src/dhosm_pkg.sv =====
// Shared types and constants for the dual hall odometer and stall monitor.
// Used by dual_hall_odometer_stall_monitor_top; depends on nothing else.
package dhosm_pkg;

  // Widths of the running counts and the millisecond timers
  localparam int COUNT_W = 32;
  localparam int TIMER_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_STALL_WIN   = 3'd1,
    REG_MIN_RUN     = 3'd2,
    REG_DISC_LIMIT  = 3'd3,
    REG_STALL_EN    = 3'd4,
    REG_MAIN_DIS    = 3'd5,
    REG_BACKUP_DIS  = 3'd6
  } reg_idx_t;

  // Configuration reset values
  localparam logic [7:0]  DEBOUNCE_RST   = 8'd5;
  localparam logic [15:0] STALL_WIN_RST  = 16'd500;
  localparam logic [15:0] MIN_RUN_RST    = 16'd10;
  localparam logic [15:0] DISC_LIMIT_RST = 16'd200;

  // Run status codes
  localparam logic [1:0] STATUS_AVG    = 2'd0;
  localparam logic [1:0] STATUS_LARGER = 2'd1;
  localparam logic [1:0] STATUS_NONE   = 2'd2;

  // Transaction between the tick stage and the reconcile stage
  typedef struct packed {
    logic [COUNT_W-1:0] main_rotations;
    logic               stalled;
    logic               run_valid;
    logic [COUNT_W-1:0] run_a;
    logic [COUNT_W-1:0] run_b;
  } tick_res_t;

  // Saturating timer increment
  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
    sat_inc = (t == TIMER_MAX) ? TIMER_MAX : t + TIMER_W'(1);
  endfunction

endpackage

// ===== src/dual_hall_odometer_stall_monitor_top.sv =====
// Dual hall odometer with stall monitor: edge counting, stall windows and
// run reconciliation. Depends on dhosm_pkg.
//
// Throughput: one tick per cycle while out_stall does not hold the output;
// the state update is done in the accept cycle, the run reconciliation
// (absolute difference, average) in a second stage.
// Reset: synchronous, active low; state and control registers go to their
// defaults; the first tick after reset counts no edge, just captures the levels.
module dual_hall_odometer_stall_monitor_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dhosm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [dhosm_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_main_level,
  input  logic                          in_backup_level,
  input  logic                          in_run_start,
  input  logic                          in_run_stop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_main_rotations,
  output logic                          out_stalled,
  output logic                          out_run_valid,
  output logic [31:0]                   out_run_rotations,
  output logic [1:0]                    out_run_status
);
  import dhosm_pkg::*;

  // Configuration registers
  logic [7:0]  debounce_r;
  logic [15:0] stall_win_r;
  logic [15:0] min_run_r;
  logic [15:0] disc_limit_r;
  logic        stall_en_r;
  logic        main_dis_r;
  logic        backup_dis_r;

  // Tick state
  logic [COUNT_W-1:0] main_count_r, backup_count_r;
  logic [COUNT_W-1:0] main_run_r, backup_run_r;
  logic               main_last_r, backup_last_r;
  logic               primed_r;
  logic [TIMER_W-1:0] main_since_r, backup_since_r;
  logic               main_armed_r, backup_armed_r;
  logic [TIMER_W-1:0] main_wtime_r, backup_wtime_r;
  logic [COUNT_W-1:0] main_snap_r, backup_snap_r;

  // Pipeline
  logic      s1_valid_r;
  tick_res_t s1_r;
  logic      out_valid_r;
  logic      out_ready, s1_ready, in_accept;

  // Next values
  logic [TIMER_W-1:0] main_since_inc, backup_since_inc;
  logic               main_edge, backup_edge;
  logic [COUNT_W-1:0] main_count_nxt, backup_count_nxt;
  logic [COUNT_W-1:0] main_run_nxt, backup_run_nxt;
  logic [TIMER_W-1:0] main_wtime_inc, backup_wtime_inc;
  logic               main_close, backup_close;
  logic               main_stall, backup_stall;
  tick_res_t          s1_nxt;

  // Reconcile stage signals
  logic               a_gt_b;
  logic [COUNT_W-1:0] diff, larger, avg;
  logic [31:0]        run_rot_nxt;
  logic [1:0]         run_status_nxt;

  // Handshake: advance when the stage ahead is empty or drains this cycle
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;
  assign out_valid = out_valid_r;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      stall_win_r  <= STALL_WIN_RST;
      min_run_r    <= MIN_RUN_RST;
      disc_limit_r <= DISC_LIMIT_RST;
      stall_en_r   <= 1'b1;
      main_dis_r   <= 1'b0;
      backup_dis_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_r   <= cfg_wdata[7:0];
        REG_STALL_WIN:  stall_win_r  <= cfg_wdata;
        REG_MIN_RUN:    min_run_r    <= cfg_wdata;
        REG_DISC_LIMIT: disc_limit_r <= cfg_wdata;
        REG_STALL_EN:   stall_en_r   <= cfg_wdata[0];
        REG_MAIN_DIS:   main_dis_r   <= cfg_wdata[0];
        REG_BACKUP_DIS: backup_dis_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Count debounced level changes
  assign main_since_inc   = sat_inc(main_since_r);
  assign backup_since_inc = sat_inc(backup_since_r);
  assign main_edge   = primed_r && (main_since_inc > TIMER_W'(debounce_r))
                       && (in_main_level != main_last_r);
  assign backup_edge = primed_r && (backup_since_inc > TIMER_W'(debounce_r))
                       && (in_backup_level != backup_last_r);
  assign main_count_nxt   = main_count_r + COUNT_W'(main_edge);
  assign backup_count_nxt = backup_count_r + COUNT_W'(backup_edge);
  assign main_run_nxt     = main_run_r + COUNT_W'(main_edge);
  assign backup_run_nxt   = backup_run_r + COUNT_W'(backup_edge);

  // Evaluate the stall windows on the new counts
  assign main_wtime_inc   = sat_inc(main_wtime_r);
  assign backup_wtime_inc = sat_inc(backup_wtime_r);
  assign main_close   = stall_en_r && main_armed_r && (main_wtime_inc > stall_win_r);
  assign backup_close = stall_en_r && backup_armed_r && (backup_wtime_inc > stall_win_r);
  assign main_stall   = main_close && (main_count_nxt == main_snap_r);
  assign backup_stall = backup_close && (backup_count_nxt == backup_snap_r);

  // Build the tick stage transaction; clamp short runs to zero
  always_comb begin
    s1_nxt.main_rotations = main_count_nxt;
    s1_nxt.stalled   = (main_stall && !main_dis_r) || (backup_stall && !backup_dis_r);
    s1_nxt.run_valid = in_run_stop;
    s1_nxt.run_a = (main_run_nxt < COUNT_W'(min_run_r)) ? '0 : main_run_nxt;
    s1_nxt.run_b = (backup_run_nxt < COUNT_W'(min_run_r)) ? '0 : backup_run_nxt;
  end

  // Update tick state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_count_r   <= '0;
      backup_count_r <= '0;
      main_run_r     <= '0;
      backup_run_r   <= '0;
      main_last_r    <= 1'b0;
      backup_last_r  <= 1'b0;
      primed_r       <= 1'b0;
      main_since_r   <= TIMER_MAX;
      backup_since_r <= TIMER_MAX;
      main_armed_r   <= 1'b0;
      backup_armed_r <= 1'b0;
      main_wtime_r   <= '0;
      backup_wtime_r <= '0;
      main_snap_r    <= '0;
      backup_snap_r  <= '0;
    end else if (in_accept) begin
      main_count_r   <= main_count_nxt;
      backup_count_r <= backup_count_nxt;
      main_run_r     <= in_run_start ? '0 : main_run_nxt;
      backup_run_r   <= in_run_start ? '0 : backup_run_nxt;
      primed_r       <= 1'b1;
      if (!primed_r || main_edge) main_last_r <= in_main_level;
      if (!primed_r || backup_edge) backup_last_r <= in_backup_level;
      main_since_r   <= main_edge ? '0 : main_since_inc;
      backup_since_r <= backup_edge ? '0 : backup_since_inc;
      if (stall_en_r) begin
        if (!main_armed_r) begin
          main_armed_r <= 1'b1;
          main_wtime_r <= '0;
          main_snap_r  <= main_count_nxt;
        end else begin
          main_wtime_r <= main_wtime_inc;
          if (main_close) main_armed_r <= 1'b0;
        end
        if (!backup_armed_r) begin
          backup_armed_r <= 1'b1;
          backup_wtime_r <= '0;
          backup_snap_r  <= backup_count_nxt;
        end else begin
          backup_wtime_r <= backup_wtime_inc;
          if (backup_close) backup_armed_r <= 1'b0;
        end
      end
    end
  end

  // Advance the tick stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_r <= s1_nxt;
  end

  // Reconcile the two run counts
  always_comb begin
    a_gt_b = s1_r.run_a > s1_r.run_b;
    diff   = a_gt_b ? (s1_r.run_a - s1_r.run_b) : (s1_r.run_b - s1_r.run_a);
    larger = a_gt_b ? s1_r.run_a : s1_r.run_b;
    avg    = (s1_r.run_a >> 1) + (s1_r.run_b >> 1)
             + COUNT_W'(s1_r.run_a[0] & s1_r.run_b[0]);
    if (!s1_r.run_valid) begin
      run_rot_nxt    = '0;
      run_status_nxt = STATUS_AVG;
    end else if ((s1_r.run_a == '0) && (s1_r.run_b == '0)) begin
      run_rot_nxt    = '0;
      run_status_nxt = STATUS_NONE;
    end else if (diff > COUNT_W'(disc_limit_r)) begin
      run_rot_nxt    = larger[31:0];
      run_status_nxt = STATUS_LARGER;
    end else begin
      run_rot_nxt    = avg[31:0];
      run_status_nxt = STATUS_AVG;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_main_rotations <= s1_r.main_rotations[31:0];
      out_stalled        <= s1_r.stalled;
      out_run_valid      <= s1_r.run_valid;
      out_run_rotations  <= run_rot_nxt;
      out_run_status     <= run_status_nxt;
    end
  end

endmodule
